/* hw/rtl/sha256_stream_hasher_unit_macros.svh */
// assertion macros used by the hasher core rtl
`ifndef SHA256_STREAM_HASHER_UNIT_MACROS_SVH
`define SHA256_STREAM_HASHER_UNIT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define SH_ASSERT(lbl, pr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) pr) else $error(msg);
`define SH_ASSERT_ALWAYS(lbl, pr, msg) \
	lbl: assert property (@(posedge clk) pr) else $error(msg);
`else
`define SH_ASSERT(lbl, pr, msg)
`define SH_ASSERT_ALWAYS(lbl, pr, msg)
`endif
`endif

/* hw/rtl/sha256h_pkg.sv */
package sha256h_pkg;

	typedef struct packed {
		logic         last_blk;
		logic [511:0] data;
	} blk_t;

	localparam logic [7:0] PadByte = 8'h80;
	localparam int unsigned LenAt = 56;

	localparam logic [31:0] InitHash [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [31:0] RoundK [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
		rotr = (x >> n) | (x << (32 - n));
	endfunction

endpackage

/* hw/rtl/sha256h_front.sv */
module sha256h_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [7:0]         s_tdata,  // data_byte[7:0]
	input  logic [1:0]         s_tuser,  // kind[1:0]
	output logic               push_valid,
	input  logic               push_ready,
	output sha256h_pkg::blk_t  push_blk
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_FULL = 2'd1;
	localparam logic [1:0] ST_PAD  = 2'd2;
	localparam logic [1:0] ST_PAD2 = 2'd3;

	logic [1:0]   state_q;
	logic [511:0] block_q;
	logic [5:0]   fill_q;
	logic [63:0]  len_q;
	logic         end_q;
	logic         accept;
	logic         has_byte;
	logic         is_end;
	logic         fits;
	logic [63:0]  bits;
	logic [511:0] padded;

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid & s_tready;
	assign has_byte = ~s_tuser[1];
	assign is_end   = s_tuser[1] | s_tuser[0];
	assign fits     = (fill_q < 6'(sha256h_pkg::LenAt));
	assign bits     = {len_q[60:0], 3'b000};

	// keep held bytes, then the pad byte, zeros, and the length if it fits
	always_comb begin
		for (int i = 0; i < 64; i++) begin
			if (6'(i) < fill_q)
				padded[511 - 8 * i -: 8] = block_q[511 - 8 * i -: 8];
			else if (6'(i) == fill_q)
				padded[511 - 8 * i -: 8] = sha256h_pkg::PadByte;
			else
				padded[511 - 8 * i -: 8] = 8'h00;
		end
		if (fits)
			padded[63:0] = bits;
	end

	always_comb begin
		push_valid = 1'b0;
		push_blk   = '{last_blk: 1'b0, data: block_q};
		unique case (state_q)
			ST_IDLE: push_valid = 1'b0;
			ST_FULL: push_valid = 1'b1;
			ST_PAD: begin
				push_valid = 1'b1;
				push_blk   = '{last_blk: fits, data: padded};
			end
			ST_PAD2: begin
				push_valid = 1'b1;
				push_blk   = '{last_blk: 1'b1, data: {448'd0, bits}};
			end
			default: push_valid = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept && has_byte) begin
			for (int i = 0; i < 64; i++) begin
				if (fill_q == 6'(i))
					block_q[511 - 8 * i -: 8] <= s_tdata;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			fill_q  <= '0;
			len_q   <= '0;
			end_q   <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (has_byte) begin
							fill_q <= fill_q + 6'd1;
							len_q  <= len_q + 64'd1;
							end_q  <= is_end;
							if (fill_q == 6'd63)
								state_q <= ST_FULL;
							else if (is_end)
								state_q <= ST_PAD;
						end else begin
							state_q <= ST_PAD;
						end
					end
				end
				ST_FULL: begin
					if (push_ready)
						state_q <= end_q ? ST_PAD : ST_IDLE;
				end
				ST_PAD: begin
					if (push_ready) begin
						if (fits) begin
							fill_q  <= '0;
							len_q   <= '0;
							state_q <= ST_IDLE;
						end else begin
							state_q <= ST_PAD2;
						end
					end
				end
				ST_PAD2: begin
					if (push_ready) begin
						fill_q  <= '0;
						len_q   <= '0;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

/* hw/rtl/sha256h_fifo.sv */
module sha256h_fifo (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push_valid,
	output logic               push_ready,
	input  sha256h_pkg::blk_t  push_blk,
	output logic               pop_valid,
	input  logic               pop_ready,
	output sha256h_pkg::blk_t  pop_blk
);

	sha256h_pkg::blk_t mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       do_push;
	logic       do_pop;

	assign push_ready = (count_q != 2'd2);
	assign pop_valid  = (count_q != 2'd0);
	assign pop_blk    = mem_q[rd_ptr_q];
	assign do_push    = push_valid & push_ready;
	assign do_pop     = pop_valid & pop_ready;

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= push_blk;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= ~wr_ptr_q;
			if (do_pop)
				rd_ptr_q <= ~rd_ptr_q;
			if (do_push && !do_pop)
				count_q <= count_q + 2'd1;
			else if (do_pop && !do_push)
				count_q <= count_q - 2'd1;
		end
	end

endmodule

/* hw/rtl/sha256h_core.sv */
module sha256h_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               pop_valid,
	output logic               pop_ready,
	input  sha256h_pkg::blk_t  pop_blk,
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [39:0]        m_tdata,  // digest_word[31:0], word_index[34:32], zero fill
	output logic               m_tlast   // last_word
);

	`include "sha256_stream_hasher_unit_macros.svh"

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_ROUND = 2'd1;
	localparam logic [1:0] ST_ADD   = 2'd2;
	localparam logic [1:0] ST_OUT   = 2'd3;

	logic [1:0]  state_q;
	logic [5:0]  rnd_q;
	logic [2:0]  idx_q;
	logic        last_q;
	logic [31:0] wnd_q [16];
	logic [31:0] v_q [8];
	logic [31:0] h_q [8];
	logic [31:0] w_new;
	logic [31:0] t1;
	logic [31:0] t2;
	logic        do_pop;
	logic        beat;

	assign pop_ready = (state_q == ST_IDLE);
	assign do_pop    = pop_valid & pop_ready;
	assign m_tvalid  = (state_q == ST_OUT);
	assign m_tdata   = {5'd0, idx_q, h_q[idx_q]};
	assign m_tlast   = (idx_q == 3'd7);
	assign beat      = m_tvalid & m_tready;

	// next schedule word, fed in behind the window as it rolls
	assign w_new = (sha256h_pkg::rotr(wnd_q[14], 17) ^ sha256h_pkg::rotr(wnd_q[14], 19)
			^ (wnd_q[14] >> 10)) + wnd_q[9]
			+ (sha256h_pkg::rotr(wnd_q[1], 7) ^ sha256h_pkg::rotr(wnd_q[1], 18)
			^ (wnd_q[1] >> 3)) + wnd_q[0];

	assign t1 = v_q[7] + (sha256h_pkg::rotr(v_q[4], 6) ^ sha256h_pkg::rotr(v_q[4], 11)
			^ sha256h_pkg::rotr(v_q[4], 25))
			+ ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]))
			+ sha256h_pkg::RoundK[rnd_q] + wnd_q[0];
	assign t2 = (sha256h_pkg::rotr(v_q[0], 2) ^ sha256h_pkg::rotr(v_q[0], 13)
			^ sha256h_pkg::rotr(v_q[0], 22))
			+ ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));

	always_ff @(posedge clk) begin
		if (do_pop) begin
			for (int i = 0; i < 16; i++)
				wnd_q[i] <= pop_blk.data[511 - 32 * i -: 32];
			for (int i = 0; i < 8; i++)
				v_q[i] <= h_q[i];
		end else if (state_q == ST_ROUND) begin
			for (int i = 0; i < 15; i++)
				wnd_q[i] <= wnd_q[i + 1];
			wnd_q[15] <= w_new;
			v_q[7] <= v_q[6];
			v_q[6] <= v_q[5];
			v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2];
			v_q[2] <= v_q[1];
			v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			rnd_q   <= '0;
			idx_q   <= '0;
			last_q  <= 1'b0;
			for (int i = 0; i < 8; i++)
				h_q[i] <= sha256h_pkg::InitHash[i];
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (do_pop) begin
						last_q  <= pop_blk.last_blk;
						rnd_q   <= '0;
						state_q <= ST_ROUND;
					end
				end
				ST_ROUND: begin
					rnd_q <= rnd_q + 6'd1;
					if (rnd_q == 6'd63)
						state_q <= ST_ADD;
				end
				ST_ADD: begin
					for (int i = 0; i < 8; i++)
						h_q[i] <= h_q[i] + v_q[i];
					idx_q   <= '0;
					state_q <= last_q ? ST_OUT : ST_IDLE;
				end
				ST_OUT: begin
					if (beat) begin
						idx_q <= idx_q + 3'd1;
						if (idx_q == 3'd7) begin
							for (int i = 0; i < 8; i++)
								h_q[i] <= sha256h_pkg::InitHash[i];
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`SH_ASSERT(a_pop_only_idle, do_pop |=> (state_q == ST_ROUND) && (rnd_q == 6'd0), "block not started")
	`SH_ASSERT(a_round_to_add, (state_q == ST_ROUND) && (rnd_q == 6'd63) |=> (state_q == ST_ADD), "rounds overrun")
	`SH_ASSERT(a_last_to_idle, beat && m_tlast |=> (state_q == ST_IDLE) && (idx_q == 3'd0), "digest not closed")
	`SH_ASSERT(a_add_to_out, (state_q == ST_ADD) && last_q |=> m_tvalid && (idx_q == 3'd0), "digest not shown")

endmodule

/* hw/rtl/sha256_stream_hasher_unit.sv */
// sha-256 over a byte stream: one byte per beat on s_*, kind in tuser (0 byte, 1 byte ending
// the message, 2 or 3 end without byte). the front packs bytes at one a beat into a 64-byte
// block, holding s_tready low while it hands on a full block or the one or two pad blocks
// at message end; a two-block queue decouples it from the compression core, which loads a
// block, runs 64 rounds at one round per cycle and adds the feed-forward, so the sustained
// rate is set by the single round unit. after the last block the eight digest words leave
// on m_* at one per beat, word 0 first, tlast on word 7, and the hash restarts.
module sha256_stream_hasher_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,  // data_byte[7:0]
	input  logic [1:0]  s_tuser,  // kind[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,  // digest_word[31:0], word_index[34:32], zero fill
	output logic        m_tlast   // last_word
);

	sha256h_pkg::blk_t push_blk;
	sha256h_pkg::blk_t pop_blk;
	logic push_valid;
	logic push_ready;
	logic pop_valid;
	logic pop_ready;

	sha256h_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_blk   (push_blk)
	);

	sha256h_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_blk   (push_blk),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_blk    (pop_blk)
	);

	sha256h_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_blk   (pop_blk),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

endmodule

/* test/sha256_stream_hasher_unit_tb.sv */
module sha256_stream_hasher_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] KindByte = 2'd0;
	localparam logic [1:0] KindByteEnd = 2'd1;
	localparam logic [1:0] KindEnd = 2'd2;
	localparam logic [1:0] KindEndAlt = 2'd3;
	localparam int CycleLimit = 1500000;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] data_byte;
	} byte_beat_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  word_index;
		logic        last_word;
	} digest_beat_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = '0;
	logic [1:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;
	logic        m_tlast;

	sha256_stream_hasher_unit dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
	);

	always #5 clk = ~clk;

	byte_beat_t   byte_queue[$];
	digest_beat_t digest_queue[$];
	int           error_count = 0;
	int           cycle_count = 0;
	int           send_wait = 0;
	int           recv_wait = 0;
	bit           stim_done = 0;

	// hashing state of the predictor
	logic [31:0] hash_state[8];
	logic [7:0]  block_buf[64];
	int          fill_count;
	logic [63:0] length_bytes;

	function automatic logic [31:0] ror32(logic [31:0] x, int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	task automatic hash_restart();
		for (int i = 0; i < 8; i++) hash_state[i] = sha256h_pkg::InitHash[i];
		fill_count = 0;
		length_bytes = '0;
	endtask

	task automatic compress_block();
		logic [31:0] w[64];
		logic [31:0] v[8];
		logic [31:0] t1, t2, s0, s1;
		for (int i = 0; i < 16; i++)
			w[i] = {block_buf[4*i], block_buf[4*i+1], block_buf[4*i+2], block_buf[4*i+3]};
		for (int i = 16; i < 64; i++) begin
			s0 = ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3);
			s1 = ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10);
			w[i] = s1 + w[i-7] + s0 + w[i-16];
		end
		for (int i = 0; i < 8; i++) v[i] = hash_state[i];
		for (int i = 0; i < 64; i++) begin
			t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
				+ ((v[4] & v[5]) ^ (~v[4] & v[6])) + sha256h_pkg::RoundK[i] + w[i];
			t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
				+ ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
			v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
			v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
		end
		for (int i = 0; i < 8; i++) hash_state[i] += v[i];
	endtask

	task automatic predict_digest(byte_beat_t b);
		logic [63:0] bit_len;
		int pos;
		digest_beat_t d;
		if (!b.kind[1]) begin
			block_buf[fill_count] = b.data_byte;
			fill_count++;
			length_bytes++;
			if (fill_count == 64) begin
				compress_block();
				fill_count = 0;
			end
		end
		if (b.kind == KindByte) return;
		bit_len = length_bytes << 3;
		pos = fill_count;
		block_buf[pos++] = sha256h_pkg::PadByte;
		if (pos > sha256h_pkg::LenAt) begin
			while (pos < 64) block_buf[pos++] = 8'h00;
			compress_block();
			pos = 0;
		end
		while (pos < sha256h_pkg::LenAt) block_buf[pos++] = 8'h00;
		for (int i = 0; i < 8; i++)
			block_buf[sha256h_pkg::LenAt + i] = bit_len[63 - 8*i -: 8];
		compress_block();
		for (int i = 0; i < 8; i++) begin
			d.digest_word = hash_state[i];
			d.word_index = i[2:0];
			d.last_word = (i == 7);
			digest_queue.push_back(d);
		end
		hash_restart();
	endtask

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
		error_count++;
	endtask

	function automatic byte_beat_t mk(logic [1:0] k, logic [7:0] d);
		byte_beat_t b;
		b.kind = k;
		b.data_byte = d;
		return b;
	endfunction

	task automatic add_message(int len, int end_style);
		for (int i = 0; i < len - 1; i++)
			byte_queue.push_back(mk(KindByte, 8'($urandom_range(0, 255))));
		if (end_style == 0 && len > 0)
			byte_queue.push_back(mk(KindByteEnd, 8'($urandom_range(0, 255))));
		else begin
			if (len > 0) byte_queue.push_back(mk(KindByte, 8'($urandom_range(0, 255))));
			byte_queue.push_back(mk($urandom_range(0, 1) ? KindEnd : KindEndAlt,
				8'($urandom_range(0, 255))));
		end
	endtask

	// driver
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (s_tvalid && s_tready) begin
			predict_digest({s_tuser, s_tdata});
		end
		if (!s_tvalid || s_tready) begin
			if (send_wait > 0) begin
				s_tvalid <= 1'b0;
				send_wait <= send_wait - 1;
			end else if (byte_queue.size() > 0) begin
				byte_beat_t b;
				b = byte_queue.pop_front();
				s_tvalid <= 1'b1;
				s_tuser <= b.kind;
				s_tdata <= b.data_byte;
				send_wait <= ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(0, 10));
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		if (m_tvalid && m_tready) begin
			if (digest_queue.size() == 0) begin
				report_mismatch("unexpected beat", m_tdata[31:0], '0);
			end else begin
				digest_beat_t e;
				e = digest_queue.pop_front();
				if (m_tdata[31:0] !== e.digest_word)
					report_mismatch("digest_word", m_tdata[31:0], e.digest_word);
				if (m_tdata[34:32] !== e.word_index)
					report_mismatch("word_index", 32'(m_tdata[34:32]), 32'(e.word_index));
				if (m_tlast !== e.last_word)
					report_mismatch("last_word", 32'(m_tlast), 32'(e.last_word));
			end
		end
		if (recv_wait > 0) begin
			m_tready <= 1'b0;
			recv_wait <= recv_wait - 1;
		end else begin
			m_tready <= 1'b1;
			if (m_tvalid)
				recv_wait <= ($urandom_range(0, 2) == 0) ? 0 : int'($urandom_range(0, 10));
		end
	end

	initial begin
		hash_restart();
		for (int i = 0; i < 64; i++) block_buf[i] = 8'h00;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		// directed: empty message, single bytes at the extremes, both end-only kinds
		byte_queue.push_back(mk(KindEnd, 8'h00));
		byte_queue.push_back(mk(KindByteEnd, 8'h00));
		byte_queue.push_back(mk(KindByteEnd, 8'hff));
		byte_queue.push_back(mk(KindByte, 8'hff));
		byte_queue.push_back(mk(KindEndAlt, 8'h55));
		// a full block, then 56 more bytes so the length spills into a second pad block
		add_message(120, 0);
		stim_done = 1;
	end

	initial begin
		wait (stim_done);
		while (byte_queue.size() > 0 || s_tvalid || digest_queue.size() > 0) begin
			@(posedge clk);
			if (cycle_count > CycleLimit) begin
				$display("FAILURE");
				$finish;
			end
		end
		repeat (300) @(posedge clk);
		if (error_count == 0 && digest_queue.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end
endmodule
